// ===== hw/rtl/srecord_line_parser_top_macros.svh =====
// ----------------------------------------------------------------------------
// S-record line parser assertion macros
// Shared concurrent assertion wrappers on clk_i / rst_ni.
// ----------------------------------------------------------------------------
`ifndef SRECORD_LINE_PARSER_TOP_MACROS_SVH
`define SRECORD_LINE_PARSER_TOP_MACROS_SVH

// checked out of reset only
`define SRLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define SRLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/srlp_pkg.sv =====
// ----------------------------------------------------------------------------
// S-record line parser package
// Shared types, character constants and record-type helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srlp_pkg;

  localparam logic [7:0] CHAR_S  = 8'h53;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF = 8'h66;
  localparam logic [7:0] SUM_OK  = 8'hFF;

  localparam logic [3:0] RT_S0 = 4'd0;
  localparam logic [3:0] RT_S1 = 4'd1;
  localparam logic [3:0] RT_S2 = 4'd2;
  localparam logic [3:0] RT_S3 = 4'd3;
  localparam logic [3:0] RT_S5 = 4'd5;
  localparam logic [3:0] RT_S7 = 4'd7;
  localparam logic [3:0] RT_S8 = 4'd8;
  localparam logic [3:0] RT_S9 = 4'd9;

  typedef enum logic [1:0] {
    LS_DONE  = 2'd0,
    LS_BUSY  = 2'd1,
    LS_ERROR = 2'd2
  } line_status_e;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic       ok;
    logic       is_digit;
    logic [3:0] digit;
    logic [3:0] nib;
  } hex_t;

  typedef struct packed {
    logic         valid;
    item_kind_e   kind;
    logic [7:0]   data_byte;
    line_status_e status;
    logic [3:0]   rtype;
    logic [31:0]  address;
    logic         addr_present;
    logic [7:0]   byte_count;
  } result_t;

  function automatic logic [2:0] addr_bytes(input logic [3:0] t);
    logic [2:0] n;
    n = 3'd0;
    if (t == RT_S0 || t == RT_S1 || t == RT_S9) n = 3'd2;
    else if (t == RT_S2 || t == RT_S8)          n = 3'd3;
    else if (t == RT_S3 || t == RT_S7)          n = 3'd4;
    return n;
  endfunction

  function automatic logic type_ok(input logic [3:0] t);
    return t == RT_S0 || t == RT_S1 || t == RT_S2 || t == RT_S3 ||
           t == RT_S5 || t == RT_S7 || t == RT_S8 || t == RT_S9;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/srlp_hex_decode.sv =====
// ----------------------------------------------------------------------------
// S-record hex character decoder
// Classifies one ASCII character as decimal digit / hex nibble.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srlp_hex_decode (
  input  wire logic [7:0]    char_i,
  output srlp_pkg::hex_t     hex_o
);

  logic is_dig, is_up, is_lo;

  always_comb begin
    is_dig = char_i >= srlp_pkg::CHAR_0  && char_i <= srlp_pkg::CHAR_9;
    is_up  = char_i >= srlp_pkg::CHAR_UA && char_i <= srlp_pkg::CHAR_UF;
    is_lo  = char_i >= srlp_pkg::CHAR_LA && char_i <= srlp_pkg::CHAR_LF;
    hex_o.is_digit = is_dig;
    hex_o.ok       = is_dig || is_up || is_lo;
    hex_o.digit    = 4'(char_i - srlp_pkg::CHAR_0);
    priority if (is_dig) begin
      hex_o.nib = 4'(char_i - srlp_pkg::CHAR_0);
    end else if (is_up) begin
      hex_o.nib = 4'(char_i - srlp_pkg::CHAR_UA + 8'd10);
    end else if (is_lo) begin
      hex_o.nib = 4'(char_i - srlp_pkg::CHAR_LA + 8'd10);
    end else begin
      hex_o.nib = 4'd0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/srlp_line_core.sv =====
// ----------------------------------------------------------------------------
// S-record line state and result logic
// Per-line state registers, next-state update and result formation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srlp_line_core #(
  parameter int unsigned MAX_LINE_CHARS = 255
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic [7:0]    char_i,
  input  wire logic          eol_i,
  output srlp_pkg::result_t  result_o
);

  localparam int unsigned PW = $clog2(MAX_LINE_CHARS + 1);
  localparam int unsigned CW = (PW > 8) ? PW : 8;
  localparam logic [PW-1:0] PosMax = PW'(MAX_LINE_CHARS);

  srlp_pkg::hex_t hex;

  logic [PW-1:0] pos_q, pos_d;
  logic [3:0]    type_q, type_d;
  logic [3:0]    hi_q, hi_d;
  logic [7:0]    count_q, count_d;
  logic [7:0]    sum_q, sum_d;
  logic [31:0]   addr_q, addr_d;
  logic [7:0]    pend_q, pend_d;
  logic          pend_vld_q, pend_vld_d;
  logic          err_q, err_d;

  logic          sat, err_now, data_fire, good;
  logic [7:0]    byte_v;
  logic [2:0]    abytes;
  logic [CW-1:0] j_ext, half_len;

  srlp_hex_decode u_hex (
    .char_i (char_i),
    .hex_o  (hex)
  );

  always_comb begin
    pos_d      = pos_q;
    type_d     = type_q;
    hi_d       = hi_q;
    count_d    = count_q;
    sum_d      = sum_q;
    addr_d     = addr_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    data_fire  = 1'b0;
    byte_v     = {hi_q, hex.nib};
    sat        = pos_q >= PosMax;
    j_ext      = CW'((pos_q - PW'(2)) >> 1);
    half_len   = CW'((pos_q - PW'(3)) >> 1);

    if (!sat && pos_q == PW'(1)) begin
      type_d = hex.is_digit ? hex.digit : 4'd0;
    end
    abytes = srlp_pkg::addr_bytes(type_d);

    priority if (sat) begin
      err_now = 1'b1;
    end else if (pos_q == '0) begin
      err_now = char_i != srlp_pkg::CHAR_S;
    end else if (pos_q == PW'(1)) begin
      err_now = !hex.is_digit || !srlp_pkg::type_ok(hex.digit);
    end else begin
      err_now = !hex.ok;
    end
    err_d = err_q | err_now;

    if (!sat && pos_q >= PW'(2)) begin
      if (!pos_q[0]) begin
        data_fire  = pend_vld_q && !eol_i && !err_d;
        pend_vld_d = 1'b0;
        hi_d       = hex.nib;
      end else begin
        sum_d = sum_q + byte_v;
        priority if (pos_q == PW'(3)) begin
          count_d = byte_v;
        end else if (j_ext <= CW'(abytes)) begin
          addr_d = {addr_q[23:0], byte_v};
        end else if (!err_d) begin
          pend_d     = byte_v;
          pend_vld_d = 1'b1;
        end
      end
    end
    if (!sat) pos_d = pos_q + PW'(1);

    good = !err_d && pos_q[0] && pos_q >= PW'(3) &&
           CW'(count_d) == half_len &&
           count_d >= 8'(abytes) + 8'd1 && sum_d == srlp_pkg::SUM_OK;

    result_o.valid = step_i && (eol_i || data_fire);
    result_o.rtype = type_d;
    if (eol_i) begin
      result_o.kind       = srlp_pkg::KIND_STATUS;
      result_o.data_byte  = 8'd0;
      result_o.byte_count = count_d;
      if (!good) begin
        result_o.status = srlp_pkg::LS_ERROR;
      end else if (type_d >= srlp_pkg::RT_S7) begin
        result_o.status = srlp_pkg::LS_DONE;
      end else begin
        result_o.status = srlp_pkg::LS_BUSY;
      end
      result_o.addr_present = good && abytes != 3'd0;
      result_o.address      = result_o.addr_present ? addr_d : 32'd0;
    end else begin
      result_o.kind         = srlp_pkg::KIND_DATA;
      result_o.data_byte    = pend_q;
      result_o.byte_count   = 8'd0;
      result_o.status       = srlp_pkg::LS_DONE;
      result_o.addr_present = 1'b0;
      result_o.address      = 32'd0;
    end

    if (eol_i) begin
      pos_d      = '0;
      type_d     = 4'd0;
      hi_d       = 4'd0;
      count_d    = 8'd0;
      sum_d      = 8'd0;
      addr_d     = 32'd0;
      pend_d     = 8'd0;
      pend_vld_d = 1'b0;
      err_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      type_q     <= 4'd0;
      hi_q       <= 4'd0;
      count_q    <= 8'd0;
      sum_q      <= 8'd0;
      addr_q     <= 32'd0;
      pend_q     <= 8'd0;
      pend_vld_q <= 1'b0;
      err_q      <= 1'b0;
    end else if (step_i) begin
      pos_q      <= pos_d;
      type_q     <= type_d;
      hi_q       <= hi_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
      addr_q     <= addr_d;
      pend_q     <= pend_d;
      pend_vld_q <= pend_vld_d;
      err_q      <= err_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/srecord_line_parser_top.sv =====
// ----------------------------------------------------------------------------
// S-record line parser
// Checks and decodes S-record lines one character per request.
//
//   channel | dir | tdata                          | tuser     | tlast
//   s_axis  | in  | char_code                      | -         | end_of_line
//   m_axis  | out | data_byte, line_status,        | item_kind | -
//           |     | record_type, record_address,   |           |
//           |     | address_present, byte_count    |           |
//
// One character per cycle unless m_axis_tready_i stalls the pipeline.
// An input register and the result register bracket the line logic.
// Reset clears line state and both valid flags.
// m_axis_tready_i low stalls the result register and then the input register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "srecord_line_parser_top_macros.svh"

module srecord_line_parser_top #(
  parameter int unsigned MAX_LINE_CHARS = 255
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  wire logic        s_axis_tlast_i,   // end_of_line
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] data_byte, [9:8] line_status, [13:10] record_type,
  // [45:14] record_address, [46] address_present, [54:47] byte_count
  output      logic [55:0] m_axis_tdata_o,
  output      logic        m_axis_tuser_o    // [0] item_kind
);

  logic              s1_valid_q;
  logic [7:0]        s1_char_q;
  logic              s1_eol_q;
  logic              out_free, s1_fire;
  logic              out_err, out_data, out_addr_clr, out_data_clr;
  srlp_pkg::result_t res;
  srlp_pkg::result_t out_q;

  assign out_free        = !out_q.valid || m_axis_tready_i;
  assign s1_fire         = s1_valid_q && out_free;
  assign s_axis_tready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      s1_char_q <= s_axis_tdata_i;
      s1_eol_q  <= s_axis_tlast_i;
    end
  end

  srlp_line_core #(
    .MAX_LINE_CHARS (MAX_LINE_CHARS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_fire),
    .char_i   (s1_char_q),
    .eol_i    (s1_eol_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (out_free) begin
      out_q.valid <= res.valid;
      if (res.valid) begin
        out_q.kind         <= res.kind;
        out_q.data_byte    <= res.data_byte;
        out_q.status       <= res.status;
        out_q.rtype        <= res.rtype;
        out_q.address      <= res.address;
        out_q.addr_present <= res.addr_present;
        out_q.byte_count   <= res.byte_count;
      end
    end
  end

  assign m_axis_tvalid_o = out_q.valid;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {1'b0, out_q.byte_count, out_q.addr_present, out_q.address,
                            out_q.rtype, out_q.status, out_q.data_byte};

  assign out_err      = out_q.valid && out_q.kind == srlp_pkg::KIND_STATUS &&
                        out_q.status == srlp_pkg::LS_ERROR;
  assign out_data     = out_q.valid && out_q.kind == srlp_pkg::KIND_DATA;
  assign out_addr_clr = !out_q.addr_present && out_q.address == 32'd0;
  assign out_data_clr = out_q.status == srlp_pkg::LS_DONE && out_q.byte_count == 8'd0 &&
                        !out_q.addr_present;

  `SRLP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_q.valid && !s1_valid_q, "valid in reset")
  `SRLP_ASSERT(a_stall_full, !s_axis_tready_o |-> s1_valid_q && out_q.valid, "stall, no backlog")
  `SRLP_ASSERT(a_err_no_addr, out_err |-> out_addr_clr, "address on error status")
  `SRLP_ASSERT(a_data_clean, out_data |-> out_data_clr, "status fields in data result")

endmodule

`default_nettype wire
